// ===== rtl/sit_pkg.sv =====
// Shared types and constants for the sorted interval table.
`timescale 1ns / 1ps
package sit_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = 8;
  localparam int CNT_W    = 9;
  localparam int TIME_W   = 48;

  typedef enum logic [2:0] {
    FN_ADD    = 3'd0,
    FN_REMOVE = 3'd1,
    FN_SPLIT  = 3'd2,
    FN_MERGE  = 3'd3,
    FN_RETIME = 3'd4,
    FN_CLEAR  = 3'd5,
    FN_MATCH  = 3'd6,
    FN_READ   = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_NO_MATCH = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_WR0,
    S_WR1,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] st;
    logic [TIME_W-1:0] en;
    logic [TIME_W-1:0] of;
  } entry_t;

endpackage

// ===== rtl/sorted_interval_table_top.sv =====
// Sorted interval table: sequencer around one block memory of entries.
//
// Input channel: in_valid / in_stall carry one command per item (func,
// entry_index, start_time, end_time, source_offset, split_time). in_stall is
// high while a command is being worked on, so one item is handled at a time.
// Output channel: out_valid / out_stall carry exactly one result item per
// command from an output register; the next command is taken while a result
// still waits there.
// Clear and a command rejected at once go straight to the result; read first
// fetches its one entry. Add and match scan every stored entry through the
// memory read port, one entry per cycle; add, remove, split, merge and retime
// then move the entries above the touched position one per cycle. Retime takes
// longest (shift down, scan, shift up). After the result is loaded the block
// returns to idle before the next item is taken. The one read port and one
// write port of the entry memory set this pace.
// Reset: the table is empty afterwards; memory contents are not cleared and
// are never read beyond the held entries.
// A stalled result holds the output register; the block finishes its
// current command and then waits before taking the next one.
`timescale 1ns / 1ps
module sorted_interval_table_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    func,
  input  logic [sit_pkg::IDX_W-1:0]     entry_index,
  input  logic [sit_pkg::TIME_W-1:0]    start_time,
  input  logic [sit_pkg::TIME_W-1:0]    end_time,
  input  logic signed [sit_pkg::TIME_W-1:0] source_offset,
  input  logic [sit_pkg::TIME_W-1:0]    split_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [sit_pkg::IDX_W-1:0]     first_index,
  output logic [sit_pkg::IDX_W-1:0]     last_index,
  output logic [sit_pkg::TIME_W-1:0]    read_start,
  output logic [sit_pkg::TIME_W-1:0]    read_end,
  output logic signed [sit_pkg::TIME_W-1:0] read_offset,
  output logic [sit_pkg::CNT_W-1:0]     entry_count
);

  localparam int CW = sit_pkg::CNT_W;
  localparam int IW = sit_pkg::IDX_W;
  localparam int TW = sit_pkg::TIME_W;

  sit_pkg::state_t state, state_next;
  sit_pkg::func_t  fn, fn_next;

  logic [IW-1:0] idx, idx_next;
  logic [TW-1:0] s_t, s_t_next, e_t, e_t_next, off, off_next, cut, cut_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rptr, rptr_next, lim, lim_next, lo, lo_next;
  logic          rvalid, rvalid_next;
  logic [CW-1:0] rtag, rtag_next;
  logic [CW-1:0] pos, pos_next;
  logic [TW-1:0] prev_end, prev_end_next, next_start, next_start_next;
  logic          have_next, have_next_next;
  logic [CW-1:0] mf, mf_next, ml, ml_next;
  logic          have_first, have_first_next, have_last, have_last_next;
  sit_pkg::entry_t ent0, ent0_next, ent1, ent1_next;
  sit_pkg::status_t res_status, res_status_next;
  logic [CW-1:0] res_first, res_first_next, res_last, res_last_next;

  // Entry memory
  sit_pkg::entry_t mem [sit_pkg::CAPACITY];
  sit_pkg::entry_t rdata, wr_data;
  logic [IW-1:0]   rd_addr, wr_addr;
  logic            rd_en, wr_en;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Handshake and shared conditions
  logic in_acc, out_free;
  logic idx_ok, scan_issue, scan_done, shup_issue, shup_done, shdn_issue, shdn_done;
  logic add_fail, split_ok, merge_ok, match_ok;
  logic [CW-1:0] idx_w;

  assign in_stall = (state != sit_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign idx_w      = {1'b0, idx};
  assign idx_ok     = {1'b0, entry_index} < count;
  assign scan_issue = rptr < lim;
  assign scan_done  = !scan_issue && !rvalid;
  assign shup_issue = rptr > lo;
  assign shup_done  = !shup_issue && !rvalid;
  assign shdn_issue = (rptr + CW'(1)) < count;
  assign shdn_done  = !shdn_issue && !rvalid;

  assign add_fail = ((pos != '0) && (s_t < prev_end)) || (have_next && (next_start < e_t));
  assign split_ok = (ent0.st < cut) && (cut < ent0.en);
  assign merge_ok = (ent0.of == ent1.of) && (ent0.en == ent1.st);
  assign match_ok = have_first && have_last && (ml >= mf);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sit_pkg::S_IDLE: begin
        if (in_acc) begin
          case (sit_pkg::func_t'(func))
            sit_pkg::FN_ADD:
              state_next = (count >= CW'(sit_pkg::CAPACITY)) ? sit_pkg::S_FIN : sit_pkg::S_SCAN;
            sit_pkg::FN_REMOVE, sit_pkg::FN_RETIME:
              state_next = idx_ok ? sit_pkg::S_SHDN : sit_pkg::S_FIN;
            sit_pkg::FN_SPLIT:
              state_next = (idx_ok && count < CW'(sit_pkg::CAPACITY)) ?
                           sit_pkg::S_SCAN : sit_pkg::S_FIN;
            sit_pkg::FN_MERGE:
              state_next = (({1'b0, entry_index} + CW'(1)) < count) ?
                           sit_pkg::S_SCAN : sit_pkg::S_FIN;
            sit_pkg::FN_MATCH: state_next = sit_pkg::S_SCAN;
            sit_pkg::FN_READ:  state_next = idx_ok ? sit_pkg::S_SCAN : sit_pkg::S_FIN;
            default:           state_next = sit_pkg::S_FIN;
          endcase
        end
      end
      sit_pkg::S_SCAN: begin
        if (scan_done) begin
          case (fn)
            sit_pkg::FN_ADD, sit_pkg::FN_RETIME:
              state_next = add_fail ? sit_pkg::S_FIN : sit_pkg::S_SHUP;
            sit_pkg::FN_SPLIT: state_next = split_ok ? sit_pkg::S_SHUP : sit_pkg::S_FIN;
            sit_pkg::FN_MERGE: state_next = merge_ok ? sit_pkg::S_WR0 : sit_pkg::S_FIN;
            default:           state_next = sit_pkg::S_FIN;
          endcase
        end
      end
      sit_pkg::S_SHUP: begin
        if (shup_done) begin
          state_next = sit_pkg::S_WR0;
        end
      end
      sit_pkg::S_SHDN: begin
        if (shdn_done) begin
          state_next = (fn == sit_pkg::FN_RETIME) ? sit_pkg::S_SCAN : sit_pkg::S_FIN;
        end
      end
      sit_pkg::S_WR0: begin
        case (fn)
          sit_pkg::FN_SPLIT: state_next = sit_pkg::S_WR1;
          sit_pkg::FN_MERGE: state_next = sit_pkg::S_SHDN;
          default:           state_next = sit_pkg::S_FIN;
        endcase
      end
      sit_pkg::S_WR1: state_next = sit_pkg::S_FIN;
      sit_pkg::S_FIN: begin
        if (out_free) begin
          state_next = sit_pkg::S_IDLE;
        end
      end
      default: state_next = sit_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory port control
  always_comb begin
    fn_next = fn; idx_next = idx; s_t_next = s_t; e_t_next = e_t;
    off_next = off; cut_next = cut; count_next = count;
    rptr_next = rptr; lim_next = lim; lo_next = lo;
    rvalid_next = 1'b0; rtag_next = rtag;
    pos_next = pos; prev_end_next = prev_end; next_start_next = next_start;
    have_next_next = have_next;
    mf_next = mf; ml_next = ml; have_first_next = have_first; have_last_next = have_last;
    ent0_next = ent0; ent1_next = ent1;
    res_status_next = res_status; res_first_next = res_first; res_last_next = res_last;
    rd_en = 1'b0; rd_addr = rptr[IW-1:0];
    wr_en = 1'b0; wr_addr = rtag[IW-1:0]; wr_data = rdata;

    case (state)
      sit_pkg::S_IDLE: begin
        if (in_acc) begin
          // Latch the command and set up its first phase
          fn_next = sit_pkg::func_t'(func);
          idx_next = entry_index;
          s_t_next = start_time;
          e_t_next = end_time;
          off_next = source_offset;
          cut_next = split_time;
          res_status_next = sit_pkg::ST_REJECT;
          res_first_next = '0;
          res_last_next = '0;
          pos_next = '0; have_next_next = 1'b0;
          have_first_next = 1'b0; have_last_next = 1'b0;
          mf_next = '0; ml_next = '0;
          rptr_next = {1'b0, entry_index};
          lo_next = {1'b0, entry_index};
          case (sit_pkg::func_t'(func))
            sit_pkg::FN_ADD, sit_pkg::FN_MATCH: begin
              rptr_next = '0;
              lim_next = count;
            end
            sit_pkg::FN_SPLIT, sit_pkg::FN_READ: lim_next = {1'b0, entry_index} + CW'(1);
            sit_pkg::FN_MERGE: lim_next = {1'b0, entry_index} + CW'(2);
            sit_pkg::FN_CLEAR: begin
              count_next = '0;
              res_status_next = sit_pkg::ST_OK;
            end
            default: lim_next = lim;
          endcase
        end
      end
      sit_pkg::S_SCAN: begin
        // Stream entries out of the memory
        if (scan_issue) begin
          rd_en = 1'b1;
          rd_addr = rptr[IW-1:0];
          rvalid_next = 1'b1;
          rtag_next = rptr;
          rptr_next = rptr + CW'(1);
        end
        if (rvalid) begin
          case (fn)
            sit_pkg::FN_ADD, sit_pkg::FN_RETIME: begin
              if (rdata.st <= s_t) begin
                pos_next = rtag + CW'(1);
                prev_end_next = rdata.en;
              end else if (!have_next) begin
                next_start_next = rdata.st;
                have_next_next = 1'b1;
              end
            end
            sit_pkg::FN_MATCH: begin
              if (!have_first && rdata.en > s_t) begin
                mf_next = rtag;
                have_first_next = 1'b1;
              end
              if (rdata.st <= e_t) begin
                ml_next = rtag;
                have_last_next = 1'b1;
              end
            end
            default: begin
              if (rtag == idx_w) begin
                ent0_next = rdata;
              end else begin
                ent1_next = rdata;
              end
            end
          endcase
        end
        if (scan_done) begin
          case (fn)
            sit_pkg::FN_ADD, sit_pkg::FN_RETIME: begin
              rptr_next = count;
              lo_next = pos;
            end
            sit_pkg::FN_SPLIT: begin
              rptr_next = count;
              lo_next = idx_w + CW'(1);
            end
            sit_pkg::FN_MATCH: begin
              if (match_ok) begin
                res_status_next = sit_pkg::ST_OK;
                res_first_next = mf;
                res_last_next = ml;
              end else begin
                res_status_next = sit_pkg::ST_NO_MATCH;
              end
            end
            sit_pkg::FN_READ: begin
              res_status_next = sit_pkg::ST_OK;
              res_first_next = idx_w;
            end
            default: rptr_next = rptr;
          endcase
        end
      end
      sit_pkg::S_SHUP: begin
        // Move entries up by one, from the top down
        if (shup_issue) begin
          rd_en = 1'b1;
          rd_addr = IW'(rptr - CW'(1));
          rvalid_next = 1'b1;
          rtag_next = rptr;
          rptr_next = rptr - CW'(1);
        end
        if (rvalid) begin
          wr_en = 1'b1;
        end
      end
      sit_pkg::S_SHDN: begin
        // Move entries down by one, from the bottom up
        if (shdn_issue) begin
          rd_en = 1'b1;
          rd_addr = IW'(rptr + CW'(1));
          rvalid_next = 1'b1;
          rtag_next = rptr;
          rptr_next = rptr + CW'(1);
        end
        if (rvalid) begin
          wr_en = 1'b1;
        end
        if (shdn_done) begin
          count_next = count - CW'(1);
          if (fn == sit_pkg::FN_RETIME) begin
            rptr_next = '0;
            lim_next = count - CW'(1);
          end else begin
            res_status_next = sit_pkg::ST_OK;
            res_first_next = idx_w;
          end
        end
      end
      sit_pkg::S_WR0: begin
        wr_en = 1'b1;
        case (fn)
          sit_pkg::FN_SPLIT: begin
            wr_addr = IW'(idx_w + CW'(1));
            wr_data = '{st: cut, en: ent0.en, of: ent0.of};
          end
          sit_pkg::FN_MERGE: begin
            wr_addr = idx;
            wr_data = '{st: ent0.st, en: ent1.en, of: ent0.of};
            rptr_next = idx_w + CW'(1);
            lo_next = idx_w + CW'(1);
          end
          default: begin
            wr_addr = pos[IW-1:0];
            wr_data = '{st: s_t, en: e_t, of: off};
            count_next = count + CW'(1);
            res_status_next = sit_pkg::ST_OK;
            res_first_next = pos;
          end
        endcase
      end
      sit_pkg::S_WR1: begin
        // Shorten the lower half of a split
        wr_en = 1'b1;
        wr_addr = idx;
        wr_data = '{st: ent0.st, en: cut, of: ent0.of};
        count_next = count + CW'(1);
        res_status_next = sit_pkg::ST_OK;
        res_first_next = idx_w;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sit_pkg::S_IDLE;
      count <= '0;
      rvalid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rvalid <= rvalid_next;
      if (state == sit_pkg::S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fn <= fn_next; idx <= idx_next; s_t <= s_t_next; e_t <= e_t_next;
    off <= off_next; cut <= cut_next;
    rptr <= rptr_next; lim <= lim_next; lo <= lo_next; rtag <= rtag_next;
    pos <= pos_next; prev_end <= prev_end_next; next_start <= next_start_next;
    have_next <= have_next_next;
    mf <= mf_next; ml <= ml_next; have_first <= have_first_next; have_last <= have_last_next;
    ent0 <= ent0_next; ent1 <= ent1_next;
    res_status <= res_status_next; res_first <= res_first_next; res_last <= res_last_next;
  end

  // Load the result item
  always_ff @(posedge clk) begin
    if (state == sit_pkg::S_FIN && out_free) begin
      status      <= res_status;
      first_index <= (res_status == sit_pkg::ST_OK) ? res_first[IW-1:0] : '0;
      last_index  <= res_last[IW-1:0];
      entry_count <= count;
      if (fn == sit_pkg::FN_READ && res_status == sit_pkg::ST_OK) begin
        read_start  <= ent0.st;
        read_end    <= ent0.en;
        read_offset <= ent0.of;
      end else begin
        read_start  <= '0;
        read_end    <= '0;
        read_offset <= '0;
      end
    end
  end

endmodule

// ===== tb/sv/tb_sorted_interval_table_top.sv =====
// Testbench for the sorted interval table: random and directed commands against a predictor.
`timescale 1ns / 1ps
module tb_sorted_interval_table_top;
  import sit_pkg::*;

  typedef struct {
    func_t             fn;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_end;
    logic [TIME_W-1:0] offset;
    logic [TIME_W-1:0] cut;
  } command_t;

  typedef struct {
    status_t           st;
    logic [IDX_W-1:0]  first;
    logic [IDX_W-1:0]  last;
    logic [TIME_W-1:0] rd_start;
    logic [TIME_W-1:0] rd_end;
    logic [TIME_W-1:0] rd_offset;
    logic [CNT_W-1:0]  count;
  } outcome_t;

  // Shadow copy of the table; predicts each outcome and checks arrivals in order
  class table_scoreboard;
    logic [TIME_W-1:0] starts[CAPACITY];
    logic [TIME_W-1:0] ends[CAPACITY];
    logic [TIME_W-1:0] offsets[CAPACITY];
    int                held;
    int                errors;
    outcome_t          pending_outcomes[$];

    function void open_slot(int pos);
      for (int i = held; i > pos; i--) begin
        starts[i]  = starts[i-1];
        ends[i]    = ends[i-1];
        offsets[i] = offsets[i-1];
      end
      held++;
    endfunction

    function void close_slot(int pos);
      for (int i = pos; i + 1 < held; i++) begin
        starts[i]  = starts[i+1];
        ends[i]    = ends[i+1];
        offsets[i] = offsets[i+1];
      end
      held--;
    endfunction

    // Upper-bound insert with overlap and capacity rejection
    function bit place_block(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e,
                             logic [TIME_W-1:0] o, output int where);
      int pos;
      pos = 0;
      where = 0;
      if (held >= CAPACITY) return 0;
      for (int i = 0; i < held; i++)
        if (starts[i] <= s) pos = i + 1;
      if (pos > 0 && s < ends[pos-1]) return 0;
      if (pos < held && starts[pos] < e) return 0;
      open_slot(pos);
      starts[pos]  = s;
      ends[pos]    = e;
      offsets[pos] = o;
      where = pos;
      return 1;
    endfunction

    function void note_item(command_t c);
      outcome_t r;
      int       pos, f, l, idx;
      bit       ok, has_f, has_l;
      r = '{ST_OK, 0, 0, 0, 0, 0, 0};
      idx = c.idx;
      ok = idx < held;
      case (c.fn)
        FN_ADD: begin
          if (place_block(c.t_start, c.t_end, c.offset, pos)) r.first = IDX_W'(pos);
          else r.st = ST_REJECT;
        end
        FN_REMOVE: begin
          if (ok) begin
            close_slot(idx);
            r.first = IDX_W'(idx);
          end else r.st = ST_REJECT;
        end
        FN_SPLIT: begin
          if (ok && held < CAPACITY && starts[idx] < c.cut && c.cut < ends[idx]) begin
            open_slot(idx + 1);
            starts[idx+1]  = c.cut;
            ends[idx+1]    = ends[idx];
            offsets[idx+1] = offsets[idx];
            ends[idx]      = c.cut;
            r.first = IDX_W'(idx);
          end else r.st = ST_REJECT;
        end
        FN_MERGE: begin
          if (idx + 1 < held && offsets[idx] == offsets[idx+1] &&
              ends[idx] == starts[idx+1]) begin
            ends[idx] = ends[idx+1];
            close_slot(idx + 1);
            r.first = IDX_W'(idx);
          end else r.st = ST_REJECT;
        end
        FN_RETIME: begin
          if (ok) begin
            close_slot(idx);
            if (place_block(c.t_start, c.t_end, c.offset, pos)) r.first = IDX_W'(pos);
            else r.st = ST_REJECT;
          end else r.st = ST_REJECT;
        end
        FN_CLEAR: held = 0;
        FN_MATCH: begin
          has_f = 0;
          has_l = 0;
          f = 0;
          l = 0;
          for (int i = 0; i < held; i++) begin
            if (!has_f && ends[i] > c.t_start) begin
              f = i;
              has_f = 1;
            end
            if (starts[i] <= c.t_end) begin
              l = i;
              has_l = 1;
            end
          end
          if (has_f && has_l && l >= f) begin
            r.first = IDX_W'(f);
            r.last  = IDX_W'(l);
          end else r.st = ST_NO_MATCH;
        end
        default: begin
          if (ok) begin
            r.first     = IDX_W'(idx);
            r.rd_start  = starts[idx];
            r.rd_end    = ends[idx];
            r.rd_offset = offsets[idx];
          end else r.st = ST_REJECT;
        end
      endcase
      r.count = CNT_W'(held);
      pending_outcomes.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t MISMATCH %s", $time, msg);
      errors++;
    endtask

    task check_result(outcome_t got);
      outcome_t exp;
      if (pending_outcomes.size() == 0) begin
        report("result item with no command outstanding");
        return;
      end
      exp = pending_outcomes.pop_front();
      if (got.st !== exp.st)
        report($sformatf("status got %0d want %0d", got.st, exp.st));
      if (got.first !== exp.first)
        report($sformatf("first_index got %0d want %0d", got.first, exp.first));
      if (got.last !== exp.last)
        report($sformatf("last_index got %0d want %0d", got.last, exp.last));
      if (got.rd_start !== exp.rd_start)
        report($sformatf("read_start got %h want %h", got.rd_start, exp.rd_start));
      if (got.rd_end !== exp.rd_end)
        report($sformatf("read_end got %h want %h", got.rd_end, exp.rd_end));
      if (got.rd_offset !== exp.rd_offset)
        report($sformatf("read_offset got %h want %h", got.rd_offset, exp.rd_offset));
      if (got.count !== exp.count)
        report($sformatf("entry_count got %0d want %0d", got.count, exp.count));
    endtask
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [2:0]               func;
  logic [IDX_W-1:0]         entry_index;
  logic [TIME_W-1:0]        start_time;
  logic [TIME_W-1:0]        end_time;
  logic signed [TIME_W-1:0] source_offset;
  logic [TIME_W-1:0]        split_time;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               status;
  logic [IDX_W-1:0]         first_index;
  logic [IDX_W-1:0]         last_index;
  logic [TIME_W-1:0]        read_start;
  logic [TIME_W-1:0]        read_end;
  logic signed [TIME_W-1:0] read_offset;
  logic [CNT_W-1:0]         entry_count;

  table_scoreboard sb;
  int              burst_left;
  int              stall_mode;
  int              stall_timer;
  logic [TIME_W-1:0] base_time;
  logic [TIME_W-1:0] unit;

  sorted_interval_table_top dut (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on run time
  initial begin
    #200ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [TIME_W-1:0] any48();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // Offer one item in bursts with random gaps; note it once accepted
  task automatic send(command_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    func          <= c.fn;
    entry_index   <= c.idx;
    start_time    <= c.t_start;
    end_time      <= c.t_end;
    source_offset <= c.offset;
    split_time    <= c.cut;
    do @(posedge clk); while (in_stall);
    sb.note_item(c);
  endtask

  task automatic cmd(func_t fn, int idx, logic [TIME_W-1:0] s, logic [TIME_W-1:0] e,
                     logic [TIME_W-1:0] o, logic [TIME_W-1:0] cut);
    command_t c;
    c = '{fn, idx[IDX_W-1:0], s, e, o, cut};
    send(c);
  endtask

  // Pick a position: mostly a held one, sometimes anywhere
  function automatic int pick_index();
    if (sb.held > 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, sb.held - 1);
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [TIME_W-1:0] grid_time(int k);
    return base_time + unit * k;
  endfunction

  function automatic logic [TIME_W-1:0] pick_offset();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return unit;
      2: return {1'b1, {(TIME_W-1){1'b0}}};
      default: return any48();
    endcase
  endfunction

  // One random command on the current time grid, with some pure noise
  task automatic random_command();
    int r, idx, k;
    logic [TIME_W-1:0] s, e, cut;
    r = $urandom_range(0, 99);
    idx = pick_index();
    k = $urandom_range(0, 40);
    s = grid_time(k);
    e = ($urandom_range(0, 9) == 0) ? any48() : grid_time(k + $urandom_range(0, 3));
    if (idx < sb.held) cut = sb.starts[idx] + $urandom_range(0, 3) * (unit / 2 + 1);
    else cut = any48();
    if (r < 35) cmd(FN_ADD, idx, s, e, pick_offset(), any48());
    else if (r < 45) cmd(FN_REMOVE, idx, any48(), any48(), any48(), any48());
    else if (r < 55) cmd(FN_SPLIT, idx, any48(), any48(), any48(), cut);
    else if (r < 65) cmd(FN_MERGE, idx, any48(), any48(), any48(), any48());
    else if (r < 72) cmd(FN_RETIME, idx, s, e, pick_offset(), any48());
    else if (r < 74) cmd(FN_CLEAR, idx, any48(), any48(), any48(), any48());
    else if (r < 86) cmd(FN_MATCH, idx, s, grid_time(k + $urandom_range(0, 8)),
                         any48(), any48());
    else if (r < 96) cmd(FN_READ, idx, any48(), any48(), any48(), any48());
    else cmd(func_t'($urandom_range(0, 7)), $urandom_range(0, 255), any48(), any48(),
             any48(), any48());
  endtask

  // Result side: check accepted items, stall on a shifting pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode = 0;
      stall_timer = 0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result('{status_t'(status), first_index, last_index, read_start, read_end,
                          read_offset, entry_count});
      if (stall_timer == 0) begin
        stall_mode  = $urandom_range(0, 3);
        stall_timer = $urandom_range(20, 300);
      end else begin
        stall_timer--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ($urandom_range(0, 63) < 2) ? ~out_stall : out_stall;
      endcase
    end
  end

  localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] O_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic [TIME_W-1:0] O_MIN = {1'b1, {(TIME_W-1){1'b0}}};

  initial begin
    int wait_cycles;
    sb = new();
    burst_left = 0;
    base_time = 0;
    unit = 100;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    func          <= FN_CLEAR;
    entry_index   <= '0;
    start_time    <= '0;
    end_time      <= '0;
    source_offset <= '0;
    split_time    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, overlaps, adjacency, merge, split edges, match edges
    cmd(FN_READ, 0, 0, 0, 0, 0);
    cmd(FN_REMOVE, 0, 0, 0, 0, 0);
    cmd(FN_MATCH, 0, 0, T_MAX, 0, 0);
    cmd(FN_ADD, 0, 100, 200, O_MAX, 0);
    cmd(FN_ADD, 0, 300, 400, O_MIN, 0);
    cmd(FN_ADD, 0, 200, 300, O_MAX, 0);
    cmd(FN_ADD, 0, 150, 250, 0, 0);
    cmd(FN_ADD, 0, 0, 0, 0, 0);
    cmd(FN_ADD, 0, 500, 450, 7, 0);
    cmd(FN_MERGE, 1, 0, 0, 0, 0);
    cmd(FN_MERGE, 1, 0, 0, 0, 0);
    cmd(FN_SPLIT, 1, 0, 0, 0, 150);
    cmd(FN_SPLIT, 1, 0, 0, 0, 100);
    cmd(FN_SPLIT, 255, 0, 0, 0, 150);
    cmd(FN_MATCH, 0, 150, 350, 0, 0);
    cmd(FN_MATCH, 0, T_MAX, T_MAX, 0, 0);
    cmd(FN_MATCH, 0, 0, 0, 0, 0);
    cmd(FN_READ, 1, 0, 0, 0, 0);
    cmd(FN_RETIME, 0, 120, 360, 1, 0);
    cmd(FN_RETIME, 0, 1000, 2000, O_MIN, 0);
    cmd(FN_ADD, 0, T_MAX, T_MAX, O_MAX, T_MAX);
    cmd(FN_READ, 255, T_MAX, T_MAX, T_MAX, T_MAX);
    cmd(FN_MERGE, 255, 0, 0, 0, 0);
    cmd(FN_CLEAR, 0, 0, 0, 0, 0);

    // Random: episodes on a fresh time grid, with one fill to capacity midway
    for (int n = 0; n < 1570; n++) begin
      if (n % 60 == 0) begin
        base_time = ($urandom_range(0, 3) == 0) ? T_MAX - $urandom_range(0, 9999) : any48();
        unit = $urandom_range(1, 5000);
      end
      if (n == 800) begin
        cmd(FN_CLEAR, 0, 0, 0, 0, 0);
        for (int k = 0; k < CAPACITY + 2; k++)
          cmd(FN_ADD, 0, grid_time(2 * k), grid_time(2 * k + 1), pick_offset(), 0);
        cmd(FN_SPLIT, 3, 0, 0, 0, grid_time(6) + 1);
        cmd(FN_MATCH, 0, 0, T_MAX, 0, 0);
        cmd(FN_READ, 255, 0, 0, 0, 0);
        cmd(FN_REMOVE, 255, 0, 0, 0, 0);
        cmd(FN_RETIME, 0, grid_time(0), grid_time(1), 0, 0);
      end
      random_command();
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then idle a while for stray outputs
    wait_cycles = 0;
    while (sb.pending_outcomes.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (600) @(posedge clk);
    if (sb.errors == 0 && sb.pending_outcomes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (sb.pending_outcomes.size() != 0)
        sb.report($sformatf("%0d results never arrived", sb.pending_outcomes.size()));
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
